// ===== rtl/usd_pkg.sv =====
// usd_pkg: shared types and byte-class constants for the utf-8 stream decoder
// no dependencies

package usd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CNT_W  = 2;

    // lead and continuation byte classes: (byte & mask) == code
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // payload masks
    localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              string_last;
    } usd_item_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic            at_string_end;
    } usd_result_t;

endpackage

// ===== rtl/usd_in_reg.sv =====
// usd_in_reg: input holding register for one byte transfer
// depends on usd_pkg

module usd_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  usd_pkg::usd_item_t in_item,
    input  logic             consume,
    output logic             item_valid,
    output usd_pkg::usd_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    usd_pkg::usd_item_t item_reg;

    // free when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/usd_core.sv =====
// usd_core: sequence state and combinational byte decode
// depends on usd_pkg

module usd_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 consume,
    input  usd_pkg::usd_item_t   item,
    output usd_pkg::usd_result_t result
);

    logic [usd_pkg::CP_W-1:0]   partial_reg;
    logic [usd_pkg::CP_W-1:0]   partial_next;
    logic [usd_pkg::CNT_W-1:0]  remain_reg;
    logic [usd_pkg::CNT_W-1:0]  remain_next;
    logic [usd_pkg::BYTE_W-1:0] b;
    logic                       is_cont;

    assign b       = item.byte_in;
    assign is_cont = (b & usd_pkg::CONT_MASK) == usd_pkg::CONT_CODE;

    always_comb
    begin
        partial_next         = partial_reg;
        remain_next          = remain_reg;
        result.emit          = 1'b0;
        result.code_point    = '0;
        result.at_string_end = item.string_last;

        if (consume)
        begin
            if (remain_reg != '0 && is_cont)
            begin
                partial_next = {partial_reg[usd_pkg::CP_W-7:0], b[5:0]};
                remain_next  = remain_reg - 1'b1;
                if (remain_reg == 2'd1)
                begin
                    result.emit       = 1'b1;
                    result.code_point = {partial_reg[usd_pkg::CP_W-7:0], b[5:0]};
                    partial_next      = '0;
                end
            end
            else
            begin
                // no sequence pending, or a bad continuation: treat as lead
                partial_next = '0;
                remain_next  = '0;
                if ((b & usd_pkg::ASCII_MASK) == usd_pkg::ASCII_CODE)
                begin
                    result.emit       = 1'b1;
                    result.code_point = {{(usd_pkg::CP_W-usd_pkg::BYTE_W){1'b0}}, b};
                end
                else if ((b & usd_pkg::LEAD2_MASK) == usd_pkg::LEAD2_CODE)
                begin
                    partial_next = {{(usd_pkg::CP_W-usd_pkg::BYTE_W){1'b0}},
                                    b & usd_pkg::LEAD2_DATA};
                    remain_next  = 2'd1;
                end
                else if ((b & usd_pkg::LEAD3_MASK) == usd_pkg::LEAD3_CODE)
                begin
                    partial_next = {{(usd_pkg::CP_W-usd_pkg::BYTE_W){1'b0}},
                                    b & usd_pkg::LEAD3_DATA};
                    remain_next  = 2'd2;
                end
                else if ((b & usd_pkg::LEAD4_MASK) == usd_pkg::LEAD4_CODE)
                begin
                    partial_next = {{(usd_pkg::CP_W-usd_pkg::BYTE_W){1'b0}},
                                    b & usd_pkg::LEAD4_DATA};
                    remain_next  = 2'd3;
                end
            end

            // end of string drops anything unfinished
            if (item.string_last)
            begin
                partial_next = '0;
                remain_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ===== rtl/usd_out_reg.sv =====
// usd_out_reg: result register holding one code point transfer
// depends on usd_pkg

module usd_out_reg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  usd_pkg::usd_result_t       result,
    output logic                       out_free,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [usd_pkg::CP_W-1:0]   code_point,
    output logic                       at_string_end
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [usd_pkg::CP_W-1:0] cp_reg;
    logic                     end_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = (load && result.emit) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.emit)
        begin
            cp_reg  <= result.code_point;
            end_reg <= result.at_string_end;
        end
    end

    assign out_valid     = valid_reg;
    assign code_point    = cp_reg;
    assign at_string_end = end_reg;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// utf8_stream_decoder: top level, utf-8 byte stream to code point decoder
// depends on usd_pkg, usd_in_reg, usd_core, usd_out_reg
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | sink      | in_valid / in_ready   | byte_in[7:0], string_last
//   out     | source    | out_valid / out_ready | code_point[20:0], at_string_end
//
// one byte per cycle sustained while out_ready stays high; a byte taken into the input
// register is decoded into the result register once the result register is free
// the decode of a byte is one short step between the input and result registers
// reset clears the pending sequence and both valid flags, no clearing pass
// a stalled result holds the byte in the input register; in_ready stays high
// whenever the result register is empty or being drained this cycle

module utf8_stream_decoder
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [usd_pkg::BYTE_W-1:0] byte_in,
    input  logic                     string_last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [usd_pkg::CP_W-1:0] code_point,
    output logic                     at_string_end
);

    usd_pkg::usd_item_t   in_item;
    usd_pkg::usd_item_t   item;
    usd_pkg::usd_result_t result;
    logic                 item_valid;
    logic                 out_free;
    logic                 consume;

    assign in_item.byte_in     = byte_in;
    assign in_item.string_last = string_last;

    // held byte is decoded when the result register can take its result
    assign consume = item_valid && out_free;

    usd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    usd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .consume (consume),
        .item    (item),
        .result  (result)
    );

    usd_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (consume),
        .result        (result),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .at_string_end (at_string_end)
    );

endmodule

// ===== rtl/usd_checker.sv =====
// usd_port_checker: port-level assertions for the utf-8 stream decoder
// depends on usd_pkg; bound to utf8_stream_decoder

module usd_port_checker
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [usd_pkg::CP_W-1:0] code_point,
    input  logic                     at_string_end
);

    // stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(at_string_end))
        else $error("result changed while stalled");

    // with an empty result register the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a draining result frees the input side in the same cycle
    a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while result drains");

    // a result needs some earlier byte transfer
    a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) || $past(in_valid, 1) || $past(out_valid, 1)
            || $past(in_ready, 2) == 1'b0 || $past(in_ready, 1) == 1'b0)
        else $error("result appeared with no byte transfer");

endmodule

bind utf8_stream_decoder usd_port_checker u_usd_port_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_point    (code_point),
    .at_string_end (at_string_end)
);
